// ----- rtl/core/corner_strength_3x3_defines.svh -----
// Assertion helpers for the corner strength block.
`ifndef CORNER_STRENGTH_3X3_DEFINES_SVH
`define CORNER_STRENGTH_3X3_DEFINES_SVH

// Clocked check, disabled while in reset.
`define CS3_CHECK(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("corner strength check failed");

// Same, with a message of its own.
`define CS3_CHECK_MSG(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

`endif

// ----- rtl/core/cs3x3_pkg.sv -----
// ----------------------------------------------------------------------------
// cs3x3_pkg
// Types and constants for the 3x3 corner strength block.
// ----------------------------------------------------------------------------
`default_nettype none

package cs3x3_pkg;

    localparam int METRIC_BITS = 16;
    localparam int ROW_BITS    = 10;
    localparam int PIX_BITS    = 4 * METRIC_BITS;

    typedef logic [METRIC_BITS-1:0] metric_t;
    typedef logic [PIX_BITS-1:0]    pixel_t;

    // configuration register indexes
    localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [2:0] REG_COLOR_THRESH = 3'd2;
    localparam logic [2:0] REG_SAA_MODE     = 3'd3;

    // metric field positions within a pixel word
    localparam int F_UP_LEFT  = 0;
    localparam int F_UP       = 1;
    localparam int F_UP_RIGHT = 2;
    localparam int F_RIGHT    = 3;

    // corner codes
    localparam logic [1:0] CORNER_TL = 2'd0;
    localparam logic [1:0] CORNER_TR = 2'd1;
    localparam logic [1:0] CORNER_BR = 2'd2;
    localparam logic [1:0] CORNER_BL = 2'd3;

    // emission codes: which pixel relative to the arriving one
    localparam logic [1:0] EMIT_UP_LEFT = 2'd0;
    localparam logic [1:0] EMIT_UP      = 2'd1;
    localparam logic [1:0] EMIT_LEFT    = 2'd2;
    localparam logic [1:0] EMIT_SELF    = 2'd3;

    localparam int DIV_STEPS = METRIC_BITS + 1;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_MEM  = 8'b0000_0010,
        ST_LOAD = 8'b0000_0100,
        ST_OPS  = 8'b0000_1000,
        ST_DIV  = 8'b0001_0000,
        ST_MUL1 = 8'b0010_0000,
        ST_MUL2 = 8'b0100_0000,
        ST_EMIT = 8'b1000_0000
    } state_t;

    function automatic metric_t field(input pixel_t p, input int k);
        field = p[k*METRIC_BITS +: METRIC_BITS];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/corner_strength_3x3.sv -----
// ----------------------------------------------------------------------------
// corner_strength_3x3
// Streamed corner strength over a raster of metric pixels, 3x3 window.
// ----------------------------------------------------------------------------
// Pixels come in raster order; two rows live in a single-port-write, dual-read
// line memory and a 3x3 window is shifted once per pixel. A request passes a
// memory read and a window shift, then releases 0 to 4 results: each result
// runs its four corners one after another through one shared restoring
// divider that makes one quotient bit a cycle, followed by two multiply
// stages. The output register lets the next request enter while a result
// still waits. A write to any of the four configuration registers restarts
// the frame at the top-left pixel. No clearing pass after reset.
`default_nettype none
`include "corner_strength_3x3_defines.svh"

module corner_strength_3x3 #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wen,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [15:0] dist_up_left,
    input  wire logic [15:0] dist_up,
    input  wire logic [15:0] dist_up_right,
    input  wire logic [15:0] dist_right,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [15:0]      strength_top_left,
    output logic [15:0]      strength_top_right,
    output logic [15:0]      strength_bottom_right,
    output logic [15:0]      strength_bottom_left,
    output logic             frame_end
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int AW    = CW + 1;
    localparam int DEPTH = 2 ** AW;
    localparam int MB    = cs3x3_pkg::METRIC_BITS;
    localparam int RB    = cs3x3_pkg::ROW_BITS;

    // configuration
    logic [10:0]   frame_width_reg;
    logic [10:0]   frame_height_reg;
    logic [MB-1:0] clr_reg;
    logic          saa_reg;

    logic [CW-1:0] col_reg;
    logic [RB-1:0] row_reg;
    logic [CW-1:0] col_last;
    logic [RB-1:0] row_last;

    cs3x3_pkg::state_t state_reg;

    // item
    cs3x3_pkg::pixel_t cur_reg;
    logic [CW-1:0]     item_col_reg;
    logic [RB-1:0]     item_row_reg;
    logic [AW-1:0]     wr_addr_reg;
    logic              item_col_last_reg;
    logic              item_row_last_reg;

    // line memory
    cs3x3_pkg::pixel_t line_mem [DEPTH];
    cs3x3_pkg::pixel_t rd_far_reg;
    cs3x3_pkg::pixel_t rd_near_reg;
    logic              mem_re;
    logic [AW-1:0]     rd_addr_far;
    logic [AW-1:0]     rd_addr_near;

    cs3x3_pkg::pixel_t win_reg [3][3];
    cs3x3_pkg::pixel_t nb_reg  [3][3];

    logic [3:0] pending_reg;
    logic [1:0] emit_sel;
    logic [1:0] emit_reg;
    logic [1:0] colsel [3];
    logic [1:0] rowsel [3];
    logic       px_right;
    logic       py_low;

    // corner datapath
    logic [1:0]    corner_reg;
    cs3x3_pkg::metric_t op_d, op_ax, op_ay, op_bx, op_by;
    logic [MB:0]   sx, sy;
    logic signed [MB+1:0] diff, cond;
    logic signed [MB+2:0] t_val;
    logic [MB:0]   w2_comb;
    logic [MB-1:0] num_diff;
    logic [MB-1:0] ax_reg, ay_reg;
    logic [MB:0]   w2_reg;
    logic          w1_zero_reg;
    logic          gate_reg;
    logic [MB-1:0] rem_reg;
    logic [MB:0]   bits_reg;
    logic [MB:0]   quo_reg;
    logic [4:0]    div_cnt_reg;
    logic [MB:0]   trial;
    logic          trial_ge;
    logic [MB:0]   w1;
    logic [2*MB+1:0] prod1;
    logic [2*MB-1:0] prod2;
    logic [MB:0]   p1_reg;
    logic [MB-1:0] p2_reg;
    logic [2*MB:0] prod3;
    logic [MB-1:0] corner_res;
    logic [MB-1:0] strength_reg [4];

    // output register
    logic          out_valid_reg;
    logic [MB-1:0] out_tl_reg, out_tr_reg, out_br_reg, out_bl_reg;
    logic          out_end_reg;
    logic          slot_free;

    // ------------------------------------------------------------------
    // effective frame size
    always_comb
    begin
        if (frame_width_reg == 11'd0)
            col_last = '0;
        else if ({21'b0, frame_width_reg} >= 32'(MAX_WIDTH))
            col_last = CW'(MAX_WIDTH - 1);
        else
            col_last = CW'(frame_width_reg - 11'd1);
        if (frame_height_reg == 11'd0)
            row_last = '0;
        else if (frame_height_reg >= 11'd1024)
            row_last = RB'(1023);
        else
            row_last = RB'(frame_height_reg - 11'd1);
    end

    assign in_ready     = (state_reg == cs3x3_pkg::ST_IDLE);
    assign mem_re       = in_valid && in_ready;
    assign rd_addr_far  = {row_reg[0], col_reg};
    assign rd_addr_near = {~row_reg[0], col_reg};
    assign slot_free    = !out_valid_reg || out_ready;

    // ------------------------------------------------------------------
    // line memory: two reads, one write
    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            rd_far_reg  <= line_mem[rd_addr_far];
            rd_near_reg <= line_mem[rd_addr_near];
        end
        if (state_reg == cs3x3_pkg::ST_MEM)
            line_mem[wr_addr_reg] <= cur_reg;
    end

    // ------------------------------------------------------------------
    // emission choice and window tap selection
    always_comb
    begin
        emit_sel = cs3x3_pkg::EMIT_SELF;
        if (pending_reg[0])
            emit_sel = cs3x3_pkg::EMIT_UP_LEFT;
        else if (pending_reg[1])
            emit_sel = cs3x3_pkg::EMIT_UP;
        else if (pending_reg[2])
            emit_sel = cs3x3_pkg::EMIT_LEFT;
        px_right = (emit_sel == cs3x3_pkg::EMIT_UP) || (emit_sel == cs3x3_pkg::EMIT_SELF);
        py_low   = (emit_sel == cs3x3_pkg::EMIT_LEFT) || (emit_sel == cs3x3_pkg::EMIT_SELF);
        // edge clamping folds onto the neighbouring window column or row
        if (px_right)
            colsel[0] = (item_col_reg == '0) ? 2'd2 : 2'd1;
        else
            colsel[0] = (item_col_reg >= CW'(2)) ? 2'd0 : 2'd1;
        colsel[1] = px_right ? 2'd2 : 2'd1;
        colsel[2] = 2'd2;
        if (py_low)
            rowsel[0] = (item_row_reg == '0) ? 2'd2 : 2'd1;
        else
            rowsel[0] = (item_row_reg >= RB'(2)) ? 2'd0 : 2'd1;
        rowsel[1] = py_low ? 2'd2 : 2'd1;
        rowsel[2] = 2'd2;
    end

    // ------------------------------------------------------------------
    // corner operands
    always_comb
    begin
        case (corner_reg)
            cs3x3_pkg::CORNER_TL:
            begin
                op_d  = cs3x3_pkg::field(nb_reg[1][0], cs3x3_pkg::F_UP_RIGHT);
                op_ax = cs3x3_pkg::field(nb_reg[1][0], cs3x3_pkg::F_RIGHT);
                op_ay = cs3x3_pkg::field(nb_reg[1][1], cs3x3_pkg::F_UP);
                op_bx = cs3x3_pkg::field(nb_reg[0][0], cs3x3_pkg::F_RIGHT);
                op_by = cs3x3_pkg::field(nb_reg[1][0], cs3x3_pkg::F_UP);
            end
            cs3x3_pkg::CORNER_TR:
            begin
                op_d  = cs3x3_pkg::field(nb_reg[1][2], cs3x3_pkg::F_UP_LEFT);
                op_ax = cs3x3_pkg::field(nb_reg[1][1], cs3x3_pkg::F_RIGHT);
                op_ay = cs3x3_pkg::field(nb_reg[1][1], cs3x3_pkg::F_UP);
                op_bx = cs3x3_pkg::field(nb_reg[0][1], cs3x3_pkg::F_RIGHT);
                op_by = cs3x3_pkg::field(nb_reg[1][2], cs3x3_pkg::F_UP);
            end
            cs3x3_pkg::CORNER_BR:
            begin
                op_d  = cs3x3_pkg::field(nb_reg[2][1], cs3x3_pkg::F_UP_RIGHT);
                op_ax = cs3x3_pkg::field(nb_reg[1][1], cs3x3_pkg::F_RIGHT);
                op_ay = cs3x3_pkg::field(nb_reg[2][1], cs3x3_pkg::F_UP);
                op_bx = cs3x3_pkg::field(nb_reg[2][1], cs3x3_pkg::F_RIGHT);
                op_by = cs3x3_pkg::field(nb_reg[2][2], cs3x3_pkg::F_UP);
            end
            default:
            begin
                op_d  = cs3x3_pkg::field(nb_reg[2][1], cs3x3_pkg::F_UP_LEFT);
                op_ax = cs3x3_pkg::field(nb_reg[1][0], cs3x3_pkg::F_RIGHT);
                op_ay = cs3x3_pkg::field(nb_reg[2][1], cs3x3_pkg::F_UP);
                op_bx = cs3x3_pkg::field(nb_reg[2][0], cs3x3_pkg::F_RIGHT);
                op_by = cs3x3_pkg::field(nb_reg[2][0], cs3x3_pkg::F_UP);
            end
        endcase

        sx   = ((op_ax < op_bx) ? {1'b0, op_ax} : {1'b0, op_bx}) + {1'b0, op_ax};
        sy   = ((op_ay < op_by) ? {1'b0, op_ay} : {1'b0, op_by}) + {1'b0, op_ay};
        diff = $signed({2'b00, op_ax}) - $signed({2'b00, op_ay});
        cond = (sx > sy) ? diff : -diff;
        t_val = $signed((MB+3)'(1) << MB) - $signed({3'b000, op_d})
              + $signed({cond[MB+1], cond});
        if (t_val < 0)
            w2_comb = '0;
        else if (t_val > $signed((MB+3)'(1) << MB))
            w2_comb = (MB+1)'(1) << MB;
        else
            w2_comb = t_val[MB:0];
        num_diff = clr_reg - op_d;
    end

    // divider step, multiplies
    assign trial    = {rem_reg, bits_reg[MB]};
    assign trial_ge = (trial >= {1'b0, clr_reg});
    assign w1       = w1_zero_reg ? '0 : quo_reg;
    assign prod1    = {1'b0, w1} * {1'b0, w2_reg};
    assign prod2    = ax_reg * ay_reg;
    assign prod3    = p1_reg * p2_reg;
    assign corner_res = gate_reg ? '0
                      : (prod3[2*MB:2*MB-MB] > (MB+1)'({MB{1'b1}})) ? {MB{1'b1}}
                      : prod3[2*MB-1:MB];

    // ------------------------------------------------------------------
    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= cs3x3_pkg::ST_IDLE;
            frame_width_reg  <= 11'd240;
            frame_height_reg <= 11'd160;
            clr_reg          <= MB'(32768);
            saa_reg          <= 1'b1;
            col_reg          <= '0;
            row_reg          <= '0;
            pending_reg      <= '0;
            corner_reg       <= cs3x3_pkg::CORNER_TL;
            div_cnt_reg      <= '0;
            out_valid_reg    <= 1'b0;
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    win_reg[i][j] <= '0;
        end
        else
        begin
            if (out_ready)
                out_valid_reg <= 1'b0;

            if (cfg_wen)
            begin
                case (cfg_index)
                    cs3x3_pkg::REG_FRAME_WIDTH:
                    begin
                        frame_width_reg <= cfg_data[10:0];
                        col_reg <= '0;
                        row_reg <= '0;
                    end
                    cs3x3_pkg::REG_FRAME_HEIGHT:
                    begin
                        frame_height_reg <= cfg_data[10:0];
                        col_reg <= '0;
                        row_reg <= '0;
                    end
                    cs3x3_pkg::REG_COLOR_THRESH:
                    begin
                        clr_reg <= cfg_data[MB-1:0];
                        col_reg <= '0;
                        row_reg <= '0;
                    end
                    cs3x3_pkg::REG_SAA_MODE:
                    begin
                        saa_reg <= cfg_data[0];
                        col_reg <= '0;
                        row_reg <= '0;
                    end
                    default:
                    begin
                    end
                endcase
            end

            case (state_reg)
                cs3x3_pkg::ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= cs3x3_pkg::ST_MEM;
                        if (col_reg == col_last)
                        begin
                            col_reg <= '0;
                            row_reg <= (row_reg == row_last) ? '0 : row_reg + RB'(1);
                        end
                        else
                            col_reg <= col_reg + CW'(1);
                    end
                end
                cs3x3_pkg::ST_MEM:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        win_reg[i][0] <= win_reg[i][1];
                        win_reg[i][1] <= win_reg[i][2];
                    end
                    win_reg[0][2] <= rd_far_reg;
                    win_reg[1][2] <= rd_near_reg;
                    win_reg[2][2] <= cur_reg;
                    pending_reg[0] <= (item_row_reg != '0) && (item_col_reg != '0);
                    pending_reg[1] <= (item_row_reg != '0) && item_col_last_reg;
                    pending_reg[2] <= item_row_last_reg && (item_col_reg != '0);
                    pending_reg[3] <= item_row_last_reg && item_col_last_reg;
                    if (((item_row_reg != '0) || item_row_last_reg)
                        && ((item_col_reg != '0) || item_col_last_reg))
                        state_reg <= cs3x3_pkg::ST_LOAD;
                    else
                        state_reg <= cs3x3_pkg::ST_IDLE;
                end
                cs3x3_pkg::ST_LOAD:
                begin
                    corner_reg <= cs3x3_pkg::CORNER_TL;
                    state_reg  <= cs3x3_pkg::ST_OPS;
                end
                cs3x3_pkg::ST_OPS:
                begin
                    div_cnt_reg <= 5'(cs3x3_pkg::DIV_STEPS - 1);
                    state_reg   <= cs3x3_pkg::ST_DIV;
                end
                cs3x3_pkg::ST_DIV:
                begin
                    div_cnt_reg <= div_cnt_reg - 5'd1;
                    if (div_cnt_reg == 5'd0)
                        state_reg <= cs3x3_pkg::ST_MUL1;
                end
                cs3x3_pkg::ST_MUL1:
                    state_reg <= cs3x3_pkg::ST_MUL2;
                cs3x3_pkg::ST_MUL2:
                begin
                    corner_reg <= corner_reg + 2'd1;
                    if (corner_reg == cs3x3_pkg::CORNER_BL)
                        state_reg <= cs3x3_pkg::ST_EMIT;
                    else
                        state_reg <= cs3x3_pkg::ST_OPS;
                end
                cs3x3_pkg::ST_EMIT:
                begin
                    if (slot_free)
                    begin
                        out_valid_reg <= 1'b1;
                        pending_reg[emit_reg] <= 1'b0;
                        if ((pending_reg & ~(4'b0001 << emit_reg)) != 4'b0000)
                            state_reg <= cs3x3_pkg::ST_LOAD;
                        else
                            state_reg <= cs3x3_pkg::ST_IDLE;
                    end
                end
                default:
                    state_reg <= cs3x3_pkg::ST_IDLE;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // datapath registers
    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            cur_reg           <= {dist_right, dist_up_right, dist_up, dist_up_left};
            item_col_reg      <= col_reg;
            item_row_reg      <= row_reg;
            wr_addr_reg       <= rd_addr_far;
            item_col_last_reg <= (col_reg == col_last);
            item_row_last_reg <= (row_reg == row_last);
        end

        if (state_reg == cs3x3_pkg::ST_LOAD)
        begin
            emit_reg <= emit_sel;
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    nb_reg[i][j] <= win_reg[rowsel[i]][colsel[j]];
        end

        if (state_reg == cs3x3_pkg::ST_OPS)
        begin
            ax_reg      <= op_ax;
            ay_reg      <= op_ay;
            w2_reg      <= w2_comb;
            w1_zero_reg <= (op_d >= clr_reg);
            gate_reg    <= !saa_reg
                        && !({1'b0, op_d, 1'b0} < ({2'b00, op_ax} + {2'b00, op_ay}));
            rem_reg     <= num_diff >> 1;
            bits_reg    <= {num_diff[0], {MB{1'b0}}};
            quo_reg     <= '0;
        end

        if (state_reg == cs3x3_pkg::ST_DIV)
        begin
            rem_reg  <= trial_ge ? MB'(trial - {1'b0, clr_reg}) : trial[MB-1:0];
            bits_reg <= bits_reg << 1;
            quo_reg  <= {quo_reg[MB-1:0], trial_ge};
        end

        if (state_reg == cs3x3_pkg::ST_MUL1)
        begin
            p1_reg <= prod1[2*MB:MB];
            p2_reg <= prod2[2*MB-1:MB];
        end

        if (state_reg == cs3x3_pkg::ST_MUL2)
            strength_reg[corner_reg] <= corner_res;

        if (state_reg == cs3x3_pkg::ST_EMIT && slot_free)
        begin
            out_tl_reg  <= strength_reg[cs3x3_pkg::CORNER_TL];
            out_tr_reg  <= strength_reg[cs3x3_pkg::CORNER_TR];
            out_br_reg  <= strength_reg[cs3x3_pkg::CORNER_BR];
            out_bl_reg  <= strength_reg[cs3x3_pkg::CORNER_BL];
            // only the bottom-right pixel of the frame is released as itself
            out_end_reg <= (emit_reg == cs3x3_pkg::EMIT_SELF);
        end
    end

    assign out_valid             = out_valid_reg;
    assign strength_top_left     = out_tl_reg;
    assign strength_top_right    = out_tr_reg;
    assign strength_bottom_right = out_br_reg;
    assign strength_bottom_left  = out_bl_reg;
    assign frame_end             = out_end_reg;

    // ------------------------------------------------------------------
    `CS3_CHECK(a_accept_to_mem, (in_valid && in_ready) |=> (state_reg == cs3x3_pkg::ST_MEM))
    `CS3_CHECK_MSG(a_div_done, (state_reg == cs3x3_pkg::ST_DIV && div_cnt_reg == 5'd0) |=> (state_reg == cs3x3_pkg::ST_MUL1), "divider overran its step count")
    `CS3_CHECK(a_emit_retires, (state_reg == cs3x3_pkg::ST_EMIT && slot_free) |=> ($countones(pending_reg) + 1 == $countones($past(pending_reg))))
    `CS3_CHECK_MSG(a_load_has_work, (state_reg == cs3x3_pkg::ST_LOAD) |-> (pending_reg != 4'b0000), "result started with nothing pending")

endmodule

`default_nettype wire

// ----- bench/corner_strength_3x3_test.sv -----
// ----------------------------------------------------------------------------
// corner_strength_3x3_test
// Self-checking bench for the 3x3 corner strength block. A clocked driver
// sends metric pixel requests from a queue in bursts with gaps. A clocked
// monitor stalls the result side on a pattern of its own and checks each
// result against a predictor of the window, the line store and the corner
// arithmetic. Frame size, threshold and mode are changed between phases,
// and only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module corner_strength_3x3_test;
    import cs3x3_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int         LSTORE_W   = 1024;
    localparam int         IDLE_WAIT  = 400;
    localparam int         N_RANDOM   = 340;
    localparam logic [2:0] REG_UNUSED = 3'd5;

    typedef logic [3:0][15:0] quad_t;   // [0] up-left, [1] up, [2] up-right, [3] right
    typedef struct packed {
        logic [15:0] tl;
        logic [15:0] tr;
        logic [15:0] br;
        logic [15:0] bl;
        logic        fe;
    } corners_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wen;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [15:0] dist_up_left;
    logic [15:0] dist_up;
    logic [15:0] dist_up_right;
    logic [15:0] dist_right;
    logic        out_valid;
    logic        out_ready;
    logic [15:0] strength_top_left;
    logic [15:0] strength_top_right;
    logic [15:0] strength_bottom_right;
    logic [15:0] strength_bottom_left;
    logic        frame_end;

    corner_strength_3x3 dut (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cfg_wen              (cfg_wen),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data),
        .in_valid             (in_valid),
        .in_ready             (in_ready),
        .dist_up_left         (dist_up_left),
        .dist_up              (dist_up),
        .dist_up_right        (dist_up_right),
        .dist_right           (dist_right),
        .out_valid            (out_valid),
        .out_ready            (out_ready),
        .strength_top_left    (strength_top_left),
        .strength_top_right   (strength_top_right),
        .strength_bottom_right(strength_bottom_right),
        .strength_bottom_left (strength_bottom_left),
        .frame_end            (frame_end)
    );

    // predictor state
    quad_t       rows_mem [2*LSTORE_W];
    quad_t       win [3][3];
    int          col_pos;
    int          row_pos;
    logic [10:0] width_reg;
    logic [10:0] height_reg;
    logic [15:0] thresh_reg;
    logic        saa_reg;

    quad_t    pixel_queue[$];
    corners_t corner_queue[$];
    bit       failed;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = 1'b1;
            #6 clk = 1'b0;
        end
    end

    function automatic logic [15:0] corner_weight(input longint unsigned d, ax, ay, bx, by);
        longint unsigned clr, w1, w2, p1, p2, r, sx, sy;
        longint          diff, cnd, t;
        clr  = thresh_reg;
        w1   = (clr == 0 || d >= clr) ? 0 : ((clr - d) << 16) / clr;
        sx   = ((ax < bx) ? ax : bx) + ax;
        sy   = ((ay < by) ? ay : by) + ay;
        diff = longint'(ax) - longint'(ay);
        cnd  = (sx > sy) ? diff : -diff;
        t    = 65536 - longint'(d) + cnd;
        if (t < 0)
            t = 0;
        if (t > 65536)
            t = 65536;
        w2 = t;
        if (!saa_reg && !(2 * d < ax + ay))
            return 16'd0;
        p1 = (w1 * w2) >> 16;
        p2 = (ax * ay) >> 16;
        r  = (p1 * p2) >> 16;
        if (r > 65535)
            r = 65535;
        return r[15:0];
    endfunction

    // neighbour lookup, clamped to the frame and then to the window
    function automatic quad_t win_at(input int x, y, c, r, w, h);
        int wr, wc;
        x  = (x < 0) ? 0 : ((x > w - 1) ? w - 1 : x);
        y  = (y < 0) ? 0 : ((y > h - 1) ? h - 1 : y);
        wr = y - (r - 2);
        wc = x - (c - 2);
        wr = (wr < 0) ? 0 : ((wr > 2) ? 2 : wr);
        wc = (wc < 0) ? 0 : ((wc > 2) ? 2 : wc);
        return win[wr][wc];
    endfunction

    function automatic corners_t pixel_corners(input int px, py, c, r, w, h);
        quad_t    a, b, dd, e, f, g, hh, i;
        corners_t res;
        a  = win_at(px - 1, py - 1, c, r, w, h);
        b  = win_at(px,     py - 1, c, r, w, h);
        dd = win_at(px - 1, py,     c, r, w, h);
        e  = win_at(px,     py,     c, r, w, h);
        f  = win_at(px + 1, py,     c, r, w, h);
        g  = win_at(px - 1, py + 1, c, r, w, h);
        hh = win_at(px,     py + 1, c, r, w, h);
        i  = win_at(px + 1, py + 1, c, r, w, h);
        res.tl = corner_weight(dd[2], dd[3], e[1], a[3], dd[1]);
        res.tr = corner_weight(f[0], e[3], e[1], b[3], f[1]);
        res.br = corner_weight(hh[2], e[3], hh[1], hh[3], i[1]);
        res.bl = corner_weight(hh[0], dd[3], hh[1], g[3], g[1]);
        res.fe = (px == w - 1 && py == h - 1);
        return res;
    endfunction

    function automatic void predict_pixel(input quad_t cur);
        int w, h, c, r, b2, b1;
        w = (width_reg < 1) ? 1 : ((width_reg > LSTORE_W) ? LSTORE_W : width_reg);
        h = (height_reg < 1) ? 1 : ((height_reg > 1024) ? 1024 : height_reg);
        if (col_pos >= w || row_pos >= h)
        begin
            col_pos = 0;
            row_pos = 0;
        end
        c  = col_pos;
        r  = row_pos;
        b2 = (r % 2) * LSTORE_W + c;
        b1 = ((r + 1) % 2) * LSTORE_W + c;
        for (int k = 0; k < 3; k++)
        begin
            win[k][0] = win[k][1];
            win[k][1] = win[k][2];
        end
        win[0][2]    = rows_mem[b2];
        win[1][2]    = rows_mem[b1];
        win[2][2]    = cur;
        rows_mem[b2] = cur;
        if (r >= 1 && c >= 1)
            corner_queue.push_back(pixel_corners(c - 1, r - 1, c, r, w, h));
        if (r >= 1 && c == w - 1)
            corner_queue.push_back(pixel_corners(c, r - 1, c, r, w, h));
        if (r == h - 1 && c >= 1)
            corner_queue.push_back(pixel_corners(c - 1, r, c, r, w, h));
        if (r == h - 1 && c == w - 1)
            corner_queue.push_back(pixel_corners(c, r, c, r, w, h));
        if (c == w - 1)
        begin
            col_pos = 0;
            row_pos = (r == h - 1) ? 0 : r + 1;
        end
        else
            col_pos = c + 1;
    endfunction

    // driver: bursts of random length, random gaps
    int burst_left;
    int gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        quad_t q;
        logic  nxt_valid;
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                predict_pixel({dist_right, dist_up_right, dist_up, dist_up_left});
            if (in_valid && !in_ready)
                nxt_valid = 1'b1;
            else if (burst_left > 0 && pixel_queue.size() > 0)
            begin
                q = pixel_queue.pop_front();
                nxt_valid = 1'b1;
                dist_up_left  <= q[0];
                dist_up       <= q[1];
                dist_up_right <= q[2];
                dist_right    <= q[3];
                burst_left    <= burst_left - 1;
            end
            else if (gap_left > 0)
            begin
                nxt_valid = 1'b0;
                gap_left <= gap_left - 1;
            end
            else
            begin
                nxt_valid = 1'b0;
                burst_left <= $urandom_range(1, 16);
                gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
            in_valid <= nxt_valid;
        end
    end

    // monitor: stall pattern changes every so often
    int stall_mode;
    int stall_count;

    always @(posedge clk or negedge rst_n)
    begin
        corners_t exp_c;
        if (!rst_n)
        begin
            out_ready   <= 1'b0;
            stall_mode  <= 0;
            stall_count <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (corner_queue.size() == 0)
                begin
                    failed = 1'b1;
                    $display("%t unexpected result tl=%h tr=%h br=%h bl=%h fe=%b", $realtime,
                             strength_top_left, strength_top_right,
                             strength_bottom_right, strength_bottom_left, frame_end);
                end
                else
                begin
                    exp_c = corner_queue.pop_front();
                    if (exp_c.tl !== strength_top_left || exp_c.tr !== strength_top_right ||
                        exp_c.br !== strength_bottom_right ||
                        exp_c.bl !== strength_bottom_left || exp_c.fe !== frame_end)
                    begin
                        failed = 1'b1;
                        $display("%t mismatch expected tl=%h tr=%h br=%h bl=%h fe=%b",
                                 $realtime, exp_c.tl, exp_c.tr, exp_c.br, exp_c.bl, exp_c.fe);
                        $display("%t          actual   tl=%h tr=%h br=%h bl=%h fe=%b",
                                 $realtime, strength_top_left, strength_top_right,
                                 strength_bottom_right, strength_bottom_left, frame_end);
                    end
                end
            end
            if (stall_count == 0)
            begin
                stall_mode  <= $urandom_range(0, 2);
                stall_count <= $urandom_range(50, 600);
            end
            else
                stall_count <= stall_count - 1;
            case (stall_mode)
                0:       out_ready <= 1'b1;
                1:       out_ready <= $urandom_range(0, 1);
                default: out_ready <= (stall_count % 5 == 0);
            endcase
        end
    end

    function automatic logic [15:0] rand_dist();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2, 3:    return $urandom_range(0, 65535);
            default: return $urandom_range(0, 20000);
        endcase
    endfunction

    task automatic wait_idle();
        while (pixel_queue.size() != 0 || in_valid || corner_queue.size() != 0)
            @(posedge clk);
        repeat (IDLE_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        @(posedge clk);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_FRAME_WIDTH:  width_reg  = val[10:0];
            REG_FRAME_HEIGHT: height_reg = val[10:0];
            REG_COLOR_THRESH: thresh_reg = val;
            REG_SAA_MODE:     saa_reg    = val[0];
            default:          return_hook();
        endcase
        if (idx <= REG_SAA_MODE)
        begin
            col_pos = 0;
            row_pos = 0;
        end
        @(posedge clk);
        cfg_wen <= 1'b0;
    endtask

    function automatic void return_hook();
        // write beyond the register list: ignored, frame position kept
    endfunction

    task automatic set_frame(input logic [15:0] w, h, thr, input logic saa);
        wait_idle();
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
        write_reg(REG_COLOR_THRESH, thr);
        write_reg(REG_SAA_MODE, {15'd0, saa});
    endtask

    int sent;
    int w_r;
    int h_r;
    int n_r;

    initial
    begin
        failed     = 1'b0;
        rst_n      = 1'b0;
        cfg_wen    = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        out_ready  = 1'b0;
        in_valid   = 1'b0;
        dist_up_left  = '0;
        dist_up       = '0;
        dist_up_right = '0;
        dist_right    = '0;
        for (int k = 0; k < 2*LSTORE_W; k++)
            rows_mem[k] = '0;
        for (int k = 0; k < 9; k++)
            win[k/3][k%3] = '0;
        col_pos    = 0;
        row_pos    = 0;
        width_reg  = 11'd240;
        height_reg = 11'd160;
        thresh_reg = 16'd32768;
        saa_reg    = 1'b1;
        repeat (3) @(posedge clk);
        rst_n = 1'b1;

        // small frame, full threshold, sum test on: field extremes
        set_frame(16'd4, 16'd3, 16'hFFFF, 1'b0);
        pixel_queue.push_back({16'h0000, 16'h0000, 16'h0000, 16'h0000});
        pixel_queue.push_back({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
        pixel_queue.push_back({16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000});
        pixel_queue.push_back({16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF});
        pixel_queue.push_back({16'h8000, 16'h0001, 16'h7FFF, 16'h1234});
        pixel_queue.push_back({16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA});
        for (int k = 0; k < 6; k++)
            pixel_queue.push_back({rand_dist(), rand_dist(), rand_dist(), rand_dist()});
        // zero threshold: all strengths zero
        set_frame(16'd1, 16'd1, 16'd0, 1'b1);
        pixel_queue.push_back({16'h0100, 16'h2000, 16'h0000, 16'h4000});
        pixel_queue.push_back({16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000});
        // oversize width acts as max, zero height acts as one row
        set_frame(16'd2047, 16'd0, 16'd655, 1'b1);
        for (int k = 0; k < 5; k++)
            pixel_queue.push_back({rand_dist(), rand_dist(), 16'd10, 16'd300});
        // zero width acts as one column, oversize height
        set_frame(16'd0, 16'd2047, 16'd40000, 1'b0);
        for (int k = 0; k < 3; k++)
            pixel_queue.push_back({rand_dist(), rand_dist(), rand_dist(), rand_dist()});
        // write past the register list must not restart the frame
        wait_idle();
        write_reg(REG_UNUSED, 16'hFFFF);
        pixel_queue.push_back({16'h0001, 16'h0002, 16'h0003, 16'h0004});

        sent = 0;
        while (sent < N_RANDOM)
        begin
            w_r = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 6);
            h_r = $urandom_range(1, 5);
            case ($urandom_range(0, 5))
                0:       set_frame(w_r, h_r, 16'd0, $urandom_range(0, 1));
                1:       set_frame(w_r, h_r, 16'd655, $urandom_range(0, 1));
                2:       set_frame(w_r, h_r, 16'hFFFF, $urandom_range(0, 1));
                default: set_frame(w_r, h_r, $urandom_range(655, 65535), $urandom_range(0, 1));
            endcase
            // mostly whole frames, sometimes a partial one
            n_r = w_r * h_r * $urandom_range(1, 2);
            if ($urandom_range(0, 3) == 0)
                n_r = $urandom_range(1, n_r);
            for (int k = 0; k < n_r; k++)
                pixel_queue.push_back({rand_dist(), rand_dist(), rand_dist(), rand_dist()});
            sent += n_r;
        end

        wait_idle();
        if (!failed)
            $display("corner_strength_3x3 regression: pass");
        else
            $display("corner_strength_3x3 regression: fail");
        $finish;
    end

    initial
    begin
        #30_000_000;
        $display("corner_strength_3x3 regression: fail");
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+rtl/core
rtl/core/cs3x3_pkg.sv
rtl/core/corner_strength_3x3.sv
bench/corner_strength_3x3_test.sv
